// ===== hw/rtl/mvat_pkg.sv =====
// Shared types and codes for the MAC plus VLAN address table.
`default_nettype none
package mvat_pkg;

  localparam int MacW  = 48;
  localparam int VlanW = 12;
  localparam int KeyW  = MacW + VlanW;
  localparam int PortW = 8;
  localparam int CapW  = 7;

  typedef enum logic [2:0] {
    K_ADD     = 3'd0,
    K_LOOKUP  = 3'd1,
    K_DELETE  = 3'd2,
    K_UPDATE  = 3'd3,
    K_CLEAR   = 3'd4,
    K_PENDING = 3'd5,
    K_BLOCK   = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    ST_INVALID = 2'd0,
    ST_ACTIVE  = 2'd1,
    ST_PENDING = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    OUT_OK   = 2'd0,
    OUT_MISS = 2'd1,
    OUT_FULL = 2'd2
  } outcome_t;

  typedef struct packed {
    kind_t              kind;
    logic [KeyW-1:0]    key;   // {vlan, mac}
    logic [PortW-1:0]   port;
  } req_t;

  typedef struct packed {
    outcome_t           outcome;
    logic [PortW-1:0]   port;
    stat_t              state;
  } res_t;

  typedef struct packed {
    logic               key_we;
    logic               port_we;
    logic               stat_we;
    logic [KeyW-1:0]    key;
    logic [PortW-1:0]   port;
    stat_t              stat;
  } mem_wr_t;

  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [PortW-1:0]   port;
    stat_t              stat;
  } mem_rd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mvat_mem.sv =====
// Slot storage: key, port and status arrays with one write and one registered read port.
`default_nettype none
module mvat_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic              clk,
  input  wire logic [AW-1:0]     rd_addr,
  output mvat_pkg::mem_rd_t      rd,
  input  wire logic [AW-1:0]     wr_addr,
  input  mvat_pkg::mem_wr_t      wr
);
  import mvat_pkg::*;

  logic [KeyW-1:0]  key_mem  [DEPTH];
  logic [PortW-1:0] port_mem [DEPTH];
  stat_t            stat_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_mem[wr_addr] <= wr.key;
    end
    if (wr.port_we) begin
      port_mem[wr_addr] <= wr.port;
    end
    if (wr.stat_we) begin
      stat_mem[wr_addr] <= wr.stat;
    end
    rd.key  <= key_mem[rd_addr];
    rd.port <= port_mem[rd_addr];
    rd.stat <= stat_mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mvat_ctrl.sv =====
// Sequencer: slot scan with the shared key comparator, write-back, clear sweep, result register.
`default_nettype none
module mvat_ctrl #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int FW    = 7
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [mvat_pkg::CapW-1:0] cap,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  mvat_pkg::req_t                in_req,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output mvat_pkg::res_t                out_res,
  output logic [AW-1:0]                 rd_addr,
  input  mvat_pkg::mem_rd_t             rd,
  output logic [AW-1:0]                 wr_addr,
  output mvat_pkg::mem_wr_t             wr
);
  import mvat_pkg::*;

  localparam int CW = (FW > CapW) ? FW : CapW;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_APPLY = 5'b00100,
    S_CLEAR = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t           state;
  logic [FW-1:0]    fill;
  logic [FW-1:0]    rd_idx;
  logic             cmp_vld;
  logic [AW-1:0]    cmp_idx;
  logic             found;
  logic [AW-1:0]    hit_idx;
  logic [PortW-1:0] hit_port;
  stat_t            hit_stat;
  req_t             req;
  res_t             res;
  res_t             res_next;
  logic             append;
  logic             full;
  logic             match;
  logic             more;
  logic [PortW-1:0] apply_port;

  assign in_ready = (state == S_IDLE);
  assign rd_addr  = rd_idx[AW-1:0];
  assign more     = (rd_idx < fill);
  assign match    = cmp_vld && (rd.stat != ST_INVALID) && (rd.key == req.key);
  // limit is min(cap, DEPTH)
  assign full     = (fill >= FW'(DEPTH)) || (CW'(fill) >= CW'(cap));
  assign apply_port = (req.kind == K_BLOCK) ? '0 : req.port;

  always_comb begin
    wr          = '0;
    wr.key      = req.key;
    wr.port     = apply_port;
    wr.stat     = ST_INVALID;
    wr_addr     = hit_idx;
    append      = 1'b0;
    res_next    = res;
    if (state == S_CLEAR) begin
      wr_addr    = rd_idx[AW-1:0];
      wr.stat_we = more;
    end else if (state == S_APPLY) begin
      case (req.kind)
        K_ADD, K_BLOCK: begin
          if (found) begin
            wr.port_we = 1'b1;
          end else if (full) begin
            res_next.outcome = OUT_FULL;
          end else begin
            append     = 1'b1;
            wr_addr    = fill[AW-1:0];
            wr.key_we  = 1'b1;
            wr.port_we = 1'b1;
            wr.stat_we = 1'b1;
            wr.stat    = ST_ACTIVE;
          end
        end
        K_LOOKUP: begin
          if (found) begin
            res_next.port  = hit_port;
            res_next.state = hit_stat;
          end else begin
            res_next.outcome = OUT_MISS;
          end
        end
        K_DELETE: begin
          if (found) wr.stat_we = 1'b1;
          else res_next.outcome = OUT_MISS;
        end
        K_UPDATE: begin
          if (found) wr.port_we = 1'b1;
          else res_next.outcome = OUT_MISS;
        end
        K_PENDING: begin
          if (found) begin
            wr.stat_we = 1'b1;
            wr.stat    = ST_PENDING;
          end else begin
            res_next.outcome = OUT_MISS;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
      cmp_vld   <= 1'b0;
      found     <= 1'b0;
    end else begin
      // in S_DONE the result register handles out_valid itself
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req         <= in_req;
            rd_idx      <= '0;
            cmp_vld     <= 1'b0;
            found       <= 1'b0;
            res.outcome <= OUT_OK;
            res.port    <= '0;
            res.state   <= ST_INVALID;
            case (in_req.kind)
              K_ADD, K_LOOKUP, K_DELETE, K_UPDATE, K_PENDING, K_BLOCK: state <= S_SCAN;
              K_CLEAR: state <= S_CLEAR;
              default: state <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          // read data is registered and follows its address in the next cycle; cmp_idx tracks it
          if (match) begin
            found    <= 1'b1;
            hit_idx  <= cmp_idx;
            hit_port <= rd.port;
            hit_stat <= rd.stat;
            state    <= S_APPLY;
          end else if (more) begin
            rd_idx  <= rd_idx + 1'b1;
            cmp_vld <= 1'b1;
            cmp_idx <= rd_idx[AW-1:0];
          end else if (cmp_vld) begin
            cmp_vld <= 1'b0;
          end else begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          res <= res_next;
          if (append) fill <= fill + 1'b1;
          state <= S_DONE;
        end
        S_CLEAR: begin
          if (more) rd_idx <= rd_idx + 1'b1;
          else state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_res   <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mac_vlan_address_table.sv =====
// Top level of the MAC plus VLAN forwarding table.
`default_nettype none
// Keyed forwarding table on {MAC, VLAN}. Entries are appended at a fill pointer
// that never moves back; deleted slots are not reused and clear-all only marks
// slots invalid. A request is taken only while the block is idle. A request that
// searches the table scans the slots up to the fill pointer: the scan reads one
// slot a cycle through the single read port of the slot memory and checks it
// with the one key comparator, after issuing the first read and before closing
// the scan; then come the write-back and the load of the result register. A hit
// ends the scan early, so a search that misses occupies the block longest, up
// to a full table of 64 slots. Clear-all writes one slot per cycle up to the
// fill pointer, and an unused kind goes straight to the result register. In
// each case the input opens in the same cycle that the result appears. The
// result register lets the next request start while a result waits; that
// request then holds in its last cycle until the earlier result is taken.
module mac_vlan_address_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata,   // capacity_in_use
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,     // mac[47:0], vlan[59:48], port[67:60], zero pad
  input  wire logic [2:0]  s_tuser,     // kind[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata      // outcome[1:0], found_port[9:2], found_state[11:10], pad
);
  import mvat_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int FW = $clog2(TABLE_DEPTH + 1);

  logic [CapW-1:0] cap;
  req_t            req;
  res_t            res;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  mem_rd_t         rd;
  mem_wr_t         wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CapW'(64);
    end else if (cfg_we) begin
      cap <= cfg_wdata;
    end
  end

  assign req.kind = kind_t'(s_tuser);
  assign req.key  = {s_tdata[59:48], s_tdata[47:0]};
  assign req.port = s_tdata[67:60];

  assign m_tdata = {4'b0000, res.state, res.port, res.outcome};

  mvat_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .FW    (FW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cap       (cap),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (req),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res),
    .rd_addr   (rd_addr),
    .rd        (rd),
    .wr_addr   (wr_addr),
    .wr        (wr)
  );

  mvat_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd      (rd),
    .wr_addr (wr_addr),
    .wr      (wr)
  );

endmodule
`default_nettype wire
